FILE: design/cnls_pkg.sv
// ----------------------------------------------------------------------------
// cnls_pkg
// Shared types and codes for the numeric literal scanner.
// ----------------------------------------------------------------------------
package cnls_pkg;

    localparam logic [3:0] K_INT     = 4'd0;
    localparam logic [3:0] K_UINT    = 4'd1;
    localparam logic [3:0] K_LONG    = 4'd2;
    localparam logic [3:0] K_ULONG   = 4'd3;
    localparam logic [3:0] K_LLONG   = 4'd4;
    localparam logic [3:0] K_ULLONG  = 4'd5;
    localparam logic [3:0] K_FLOAT   = 4'd6;
    localparam logic [3:0] K_DOUBLE  = 4'd7;
    localparam logic [3:0] K_LDOUBLE = 4'd8;

    localparam logic [1:0] BASE_OCT = 2'd0;
    localparam logic [1:0] BASE_DEC = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_NO_HEX  = 2'd1;
    localparam logic [1:0] ERR_NO_EXP  = 2'd2;

    typedef enum logic [11:0] {
        PH_IDLE      = 12'b0000_0000_0001,
        PH_ZERO      = 12'b0000_0000_0010,
        PH_INTDIG    = 12'b0000_0000_0100,
        PH_HEXSTART  = 12'b0000_0000_1000,
        PH_AFTER_U   = 12'b0000_0001_0000,
        PH_AFTER_L   = 12'b0000_0010_0000,
        PH_INTDONE   = 12'b0000_0100_0000,
        PH_FRAC      = 12'b0000_1000_0000,
        PH_EXPMARK   = 12'b0001_0000_0000,
        PH_EXPSIGNED = 12'b0010_0000_0000,
        PH_EXPDIG    = 12'b0100_0000_0000,
        PH_FLTDONE   = 12'b1000_0000_0000
    } phase_t;

    // classified character, front to back
    typedef struct packed {
        logic       begins;
        logic       is_dec;
        logic       is_hexlet;
        logic [3:0] nib;
        logic       is_zero;
        logic       is_x;
        logic       is_dot;
        logic       is_e;
        logic       is_u;
        logic       is_l;
        logic       is_f;
        logic       is_sign;
    } cls_t;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] value;
        logic        too_big;
        logic [1:0]  error_code;
        logic [1:0]  literal_base;
    } res_t;

endpackage

FILE: design/c_numeric_literal_scanner_top.sv
// ----------------------------------------------------------------------------
// c_numeric_literal_scanner_top
// Scans C numeric literals from a byte stream, one result per literal.
// ----------------------------------------------------------------------------
// Input channel: character and begins are written with push while full is
// low; begins marks the first byte of a literal. Result channel: while empty
// is low the oldest result sits on kind/value/too_big/error_code/literal_base
// and is taken with pop.
// A literal ends on the first byte that does not belong to it (or on a new
// begins mark); its result goes into the result queue when the scanner steps
// on that byte: the accepting edge writes the classifier queue, and the scanner
// step that takes the byte from there, which waits while the result queue is full, writes the result queue.
// Throughput is one byte per cycle while the result queue has room, set by
// the scanner step (one shift-add on the accumulator and a phase update).
// Both sides hold two items. When the receiver stalls, the scanner stops once
// the result queue is full, then the input queue fills and full rises.
// Reset clears both queues and returns the scanner to idle; no result is
// pending afterwards.
// ----------------------------------------------------------------------------
module c_numeric_literal_scanner_top
    import cnls_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  character,
    input  logic        begins,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  kind,
    output logic [31:0] value,
    output logic        too_big,
    output logic [1:0]  error_code,
    output logic [1:0]  literal_base
);

    logic q_valid;
    logic q_pop;
    cls_t q_item;

    cnls_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .character (character),
        .begins    (begins),
        .push      (push),
        .full      (full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    cnls_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .value        (value),
        .too_big      (too_big),
        .error_code   (error_code),
        .literal_base (literal_base)
    );

endmodule

FILE: design/cnls_front.sv
// ----------------------------------------------------------------------------
// cnls_front
// Accepts characters, classifies them and holds them in a two-item queue.
// ----------------------------------------------------------------------------
module cnls_front
    import cnls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] character,
    input  logic       begins,
    input  logic       push,
    output logic       full,
    output logic       q_valid,
    output cls_t       q_item,
    input  logic       q_pop
);

    cls_t       cls;
    cls_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    always_comb
    begin
        cls.begins    = begins;
        cls.is_dec    = (character >= 8'h30) && (character <= 8'h39);
        cls.is_hexlet = ((character >= 8'h61) && (character <= 8'h66)) ||
                        ((character >= 8'h41) && (character <= 8'h46));
        cls.nib       = cls.is_dec ? character[3:0] : character[3:0] + 4'd9;
        cls.is_zero   = (character == 8'h30);
        cls.is_x      = (character == 8'h78) || (character == 8'h58);
        cls.is_dot    = (character == 8'h2e);
        cls.is_e      = (character == 8'h65) || (character == 8'h45);
        cls.is_u      = (character == 8'h75) || (character == 8'h55);
        cls.is_l      = (character == 8'h6c) || (character == 8'h4c);
        cls.is_f      = (character == 8'h66) || (character == 8'h46);
        cls.is_sign   = (character == 8'h2b) || (character == 8'h2d);
    end

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

FILE: design/cnls_back.sv
// ----------------------------------------------------------------------------
// cnls_back
// Literal state machine and accumulator; results go to a two-item queue.
// ----------------------------------------------------------------------------
module cnls_back
    import cnls_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cls_t        q_item,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  kind,
    output logic [31:0] value,
    output logic        too_big,
    output logic [1:0]  error_code,
    output logic [1:0]  literal_base
);

    localparam int W = VALUE_BITS;

    phase_t         phase_reg, phase_next;
    logic [W-1:0]   acc_reg, acc_next;
    logic           ovf_reg, ovf_next;
    logic [1:0]     base_reg, base_next;
    logic [3:0]     kind_reg, kind_next;
    logic [1:0]     err_reg, err_next;

    phase_t         ph_a;
    logic [W-1:0]   acc_a;
    logic           ovf_a;
    logic [1:0]     base_a;
    logic [3:0]     kind_a;
    logic [1:0]     err_a;
    logic           keep;

    cls_t           c;
    logic           digit_ok;
    logic [W+3:0]   prod;
    logic [W+3:0]   sum;
    logic [W-1:0]   acc_step;
    logic           ovf_step;

    logic           step, active, emit;
    logic [3:0]     ek;
    logic [W-1:0]   eacc;
    logic           eovf;
    logic [1:0]     eerr, ebase;
    logic [W+31:0]  eacc_ext;
    res_t           res;

    res_t           mem_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg, count_next;
    logic           out_full, do_push, do_pop;

    assign c = q_item;

    always_comb
    begin
        unique case (base_reg)
            BASE_OCT: digit_ok = c.is_dec && !c.nib[3];
            BASE_DEC: digit_ok = c.is_dec;
            BASE_HEX: digit_ok = c.is_dec || c.is_hexlet;
            default:  digit_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (base_reg)
            BASE_OCT: prod = {1'b0, acc_reg, 3'b000};
            BASE_HEX: prod = {acc_reg, 4'b0000};
            default:  prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
        endcase
        sum      = prod + {{W{1'b0}}, c.nib};
        acc_step = sum[W-1:0];
        ovf_step = ovf_reg || (|sum[W+3:W]);
    end

    // advance the open literal by one character
    always_comb
    begin
        ph_a   = phase_reg;
        acc_a  = acc_reg;
        ovf_a  = ovf_reg;
        base_a = base_reg;
        kind_a = kind_reg;
        err_a  = err_reg;
        keep   = 1'b0;
        unique case (phase_reg)
            PH_ZERO, PH_INTDIG:
            begin
                if ((phase_reg == PH_ZERO) && c.is_x)
                begin
                    base_a = BASE_HEX;
                    ph_a   = PH_HEXSTART;
                    keep   = 1'b1;
                end
                else
                begin
                    ph_a = PH_INTDIG;
                    priority if (digit_ok)
                    begin
                        acc_a = acc_step;
                        ovf_a = ovf_step;
                        keep  = 1'b1;
                    end
                    else if ((base_reg != BASE_HEX) && c.is_dot)
                    begin
                        kind_a = K_DOUBLE;
                        ph_a   = PH_FRAC;
                        keep   = 1'b1;
                    end
                    else if ((base_reg != BASE_HEX) && c.is_e)
                    begin
                        kind_a = K_DOUBLE;
                        ph_a   = PH_EXPMARK;
                        keep   = 1'b1;
                    end
                    else if (c.is_u)
                    begin
                        kind_a = K_UINT;
                        ph_a   = PH_AFTER_U;
                        keep   = 1'b1;
                    end
                    else if (c.is_l)
                    begin
                        kind_a = K_LONG;
                        ph_a   = PH_AFTER_L;
                        keep   = 1'b1;
                    end
                    else
                    begin
                        keep = 1'b0;
                    end
                end
            end
            PH_HEXSTART:
            begin
                if (digit_ok)
                begin
                    acc_a = acc_step;
                    ovf_a = ovf_step;
                    ph_a  = PH_INTDIG;
                    keep  = 1'b1;
                end
                else
                begin
                    err_a  = ERR_NO_HEX;
                    acc_a  = '0;
                    ovf_a  = 1'b0;
                    kind_a = K_INT;
                end
            end
            PH_AFTER_U:
            begin
                if (c.is_l)
                begin
                    kind_a = K_ULONG;
                    ph_a   = PH_AFTER_L;
                    keep   = 1'b1;
                end
            end
            PH_AFTER_L:
            begin
                if (c.is_l)
                begin
                    kind_a = (kind_reg == K_ULONG) ? K_ULLONG : K_LLONG;
                    ph_a   = PH_INTDONE;
                    keep   = 1'b1;
                end
            end
            PH_FRAC, PH_EXPMARK, PH_EXPSIGNED, PH_EXPDIG:
            begin
                priority if ((phase_reg == PH_FRAC || phase_reg == PH_EXPDIG) && c.is_dec)
                begin
                    keep = 1'b1;
                end
                else if ((phase_reg == PH_FRAC) && c.is_e)
                begin
                    ph_a = PH_EXPMARK;
                    keep = 1'b1;
                end
                else if ((phase_reg == PH_EXPMARK) && c.is_sign)
                begin
                    ph_a = PH_EXPSIGNED;
                    keep = 1'b1;
                end
                else if ((phase_reg == PH_EXPMARK || phase_reg == PH_EXPSIGNED) && c.is_dec)
                begin
                    ph_a = PH_EXPDIG;
                    keep = 1'b1;
                end
                else
                begin
                    if (phase_reg == PH_EXPMARK || phase_reg == PH_EXPSIGNED)
                    begin
                        err_a = ERR_NO_EXP;
                    end
                    if (c.is_f)
                    begin
                        kind_a = K_FLOAT;
                        ph_a   = PH_FLTDONE;
                        keep   = 1'b1;
                    end
                    else if (c.is_l)
                    begin
                        kind_a = K_LDOUBLE;
                        ph_a   = PH_FLTDONE;
                        keep   = 1'b1;
                    end
                end
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign out_full = (count_reg == 2'd2);
    assign step     = q_valid && !out_full;
    assign q_pop    = step;
    assign active   = (phase_reg != PH_IDLE);
    assign emit     = active && (c.begins || !keep);

    always_comb
    begin
        ek    = c.begins ? kind_reg : kind_a;
        eacc  = c.begins ? acc_reg  : acc_a;
        eovf  = c.begins ? ovf_reg  : ovf_a;
        eerr  = c.begins ? err_reg  : err_a;
        ebase = c.begins ? base_reg : base_a;
        eacc_ext         = {32'd0, eacc};
        res.kind         = ek;
        res.value        = (ek >= K_FLOAT) ? 32'd0 : eacc_ext[31:0];
        res.too_big      = (ek >= K_FLOAT) ? 1'b0 : eovf;
        res.error_code   = eerr;
        res.literal_base = ebase;
    end

    // next state, with the start of a new literal on a marked character
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        base_next  = base_reg;
        kind_next  = kind_reg;
        err_next   = err_reg;
        if (c.begins)
        begin
            acc_next  = '0;
            ovf_next  = 1'b0;
            err_next  = ERR_NONE;
            kind_next = K_INT;
            base_next = BASE_DEC;
            phase_next = PH_IDLE;
            priority if (c.is_zero)
            begin
                base_next  = BASE_OCT;
                phase_next = PH_ZERO;
            end
            else if (c.is_dec)
            begin
                acc_next   = {{(W-4){1'b0}}, c.nib};
                phase_next = PH_INTDIG;
            end
            else if (c.is_dot)
            begin
                kind_next  = K_DOUBLE;
                phase_next = PH_FRAC;
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end
        else if (active)
        begin
            phase_next = keep ? ph_a : PH_IDLE;
            acc_next   = acc_a;
            ovf_next   = ovf_a;
            base_next  = base_a;
            kind_next  = kind_a;
            err_next   = err_a;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            acc_reg   <= '0;
            ovf_reg   <= 1'b0;
            base_reg  <= BASE_DEC;
            kind_reg  <= K_INT;
            err_reg   <= ERR_NONE;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            base_reg  <= base_next;
            kind_reg  <= kind_next;
            err_reg   <= err_next;
        end
    end

    // result queue
    assign do_push = step && emit;
    assign do_pop  = pop && !empty;
    assign empty   = (count_reg == 2'd0);

    always_comb
    begin
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= res;
        end
    end

    assign kind         = mem_reg[rd_ptr_reg].kind;
    assign value        = mem_reg[rd_ptr_reg].value;
    assign too_big      = mem_reg[rd_ptr_reg].too_big;
    assign error_code   = mem_reg[rd_ptr_reg].error_code;
    assign literal_base = mem_reg[rd_ptr_reg].literal_base;

endmodule

FILE: tb/sv/c_numeric_literal_scanner_top_tb.sv
// ----------------------------------------------------------------------------
// c_numeric_literal_scanner_top_tb
// Self-checking bench for the C numeric literal scanner.
// ----------------------------------------------------------------------------
// Bytes are pushed one item at a time. A scoreboard follows the literal
// grammar on every accepted byte and queues the result each closed literal
// should give. Results popped from the block are compared in order.
// Stimulus is a short directed set of corner literals, then random
// literals of every form, with noise bytes and broken sequences mixed in.
// Both sides idle at random, apart from one quiet stretch, and the sender
// drains the block once part way through.
// ----------------------------------------------------------------------------
module c_numeric_literal_scanner_top_tb;
    import cnls_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 8;
    localparam int RANDOM_ITEMS = 400;
    localparam int NO_DIGIT     = 99;
    localparam int SHOWN_ERRORS = 10;

    class literal_scoreboard;
        phase_t      ph;
        logic [63:0] acc;
        logic        ovf;
        logic [1:0]  base;
        logic [3:0]  sfx;
        logic [1:0]  err;
        res_t        want_q[$];
        int          mismatches;

        function new();
            ph         = PH_IDLE;
            acc        = '0;
            ovf        = 1'b0;
            base       = BASE_DEC;
            sfx        = K_INT;
            err        = ERR_NONE;
            mismatches = 0;
        endfunction

        function int radix_of();
            if (base == BASE_OCT)
            begin
                return 8;
            end
            if (base == BASE_HEX)
            begin
                return 16;
            end
            return 10;
        endfunction

        function int digit_of(logic [7:0] c, int rad);
            int d;
            d = NO_DIGIT;
            if (c >= "0" && c <= "9")
                d = int'(c - "0");
            else if (c >= "a" && c <= "f")
                d = int'(c - "a") + 10;
            else if (c >= "A" && c <= "F")
                d = int'(c - "A") + 10;
            return (d < rad) ? d : NO_DIGIT;
        endfunction

        function void add_digit(int d);
            logic [63:0] m;
            logic [63:0] r;
            logic [63:0] dd;
            m  = 64'hFFFF_FFFF;
            r  = 64'(radix_of());
            dd = 64'(d);
            if (acc > (m - dd) / r)
                ovf = 1'b1;
            acc = (acc * r + dd) & m;
        endfunction

        function bit float_suffix(logic [7:0] c);
            if (c == "f" || c == "F")
            begin
                sfx = K_FLOAT;
                ph  = PH_FLTDONE;
                return 1'b1;
            end
            if (c == "l" || c == "L")
            begin
                sfx = K_LDOUBLE;
                ph  = PH_FLTDONE;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // 1 when the byte extends the open literal
        function bit extends_literal(logic [7:0] c);
            int d;
            bit is_l;
            bit is_dig;
            is_l   = (c == "l" || c == "L");
            is_dig = (c >= "0" && c <= "9");
            if (ph == PH_ZERO)
            begin
                if (c == "x" || c == "X")
                begin
                    base = BASE_HEX;
                    ph   = PH_HEXSTART;
                    return 1'b1;
                end
                ph = PH_INTDIG;
            end
            case (ph)
                PH_INTDIG:
                begin
                    d = digit_of(c, radix_of());
                    if (d != NO_DIGIT)
                    begin
                        add_digit(d);
                        return 1'b1;
                    end
                    if (base != BASE_HEX && c == ".")
                    begin
                        sfx = K_DOUBLE;
                        ph  = PH_FRAC;
                        return 1'b1;
                    end
                    if (base != BASE_HEX && (c == "e" || c == "E"))
                    begin
                        sfx = K_DOUBLE;
                        ph  = PH_EXPMARK;
                        return 1'b1;
                    end
                    if (c == "u" || c == "U")
                    begin
                        sfx = K_UINT;
                        ph  = PH_AFTER_U;
                        return 1'b1;
                    end
                    if (is_l)
                    begin
                        sfx = K_LONG;
                        ph  = PH_AFTER_L;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                PH_HEXSTART:
                begin
                    d = digit_of(c, 16);
                    if (d != NO_DIGIT)
                    begin
                        add_digit(d);
                        ph = PH_INTDIG;
                        return 1'b1;
                    end
                    err = ERR_NO_HEX;
                    acc = '0;
                    ovf = 1'b0;
                    sfx = K_INT;
                    return 1'b0;
                end
                PH_AFTER_U:
                begin
                    if (is_l)
                    begin
                        sfx = K_ULONG;
                        ph  = PH_AFTER_L;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                PH_AFTER_L:
                begin
                    if (is_l)
                    begin
                        sfx = (sfx == K_ULONG) ? K_ULLONG : K_LLONG;
                        ph  = PH_INTDONE;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                PH_FRAC:
                begin
                    if (is_dig)
                        return 1'b1;
                    if (c == "e" || c == "E")
                    begin
                        ph = PH_EXPMARK;
                        return 1'b1;
                    end
                    return float_suffix(c);
                end
                PH_EXPMARK:
                begin
                    if (c == "+" || c == "-")
                    begin
                        ph = PH_EXPSIGNED;
                        return 1'b1;
                    end
                    if (is_dig)
                    begin
                        ph = PH_EXPDIG;
                        return 1'b1;
                    end
                    err = ERR_NO_EXP;
                    return float_suffix(c);
                end
                PH_EXPSIGNED:
                begin
                    if (is_dig)
                    begin
                        ph = PH_EXPDIG;
                        return 1'b1;
                    end
                    err = ERR_NO_EXP;
                    return float_suffix(c);
                end
                PH_EXPDIG:
                begin
                    if (is_dig)
                        return 1'b1;
                    return float_suffix(c);
                end
                default:
                    return 1'b0;
            endcase
        endfunction

        function void close_literal();
            res_t r;
            bit   flt;
            flt            = (sfx >= K_FLOAT);
            r.kind         = sfx;
            r.value        = flt ? 32'd0 : acc[31:0];
            r.too_big      = flt ? 1'b0 : ovf;
            r.error_code   = err;
            r.literal_base = base;
            want_q.push_back(r);
            ph = PH_IDLE;
        endfunction

        function void open_literal(logic [7:0] c);
            acc  = '0;
            ovf  = 1'b0;
            err  = ERR_NONE;
            sfx  = K_INT;
            base = BASE_DEC;
            ph   = PH_IDLE;
            if (c == "0")
            begin
                base = BASE_OCT;
                ph   = PH_ZERO;
            end
            else if (c >= "1" && c <= "9")
            begin
                acc = {56'd0, 8'(c - "0")};
                ph  = PH_INTDIG;
            end
            else if (c == ".")
            begin
                sfx = K_DOUBLE;
                ph  = PH_FRAC;
            end
        endfunction

        function void note_item(logic [7:0] c, logic mark);
            if (ph != PH_IDLE)
            begin
                if (mark)
                    close_literal();
                else if (!extends_literal(c))
                    close_literal();
            end
            if (mark)
                open_literal(c);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (want_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("unexpected result: kind %0d value %h too_big %0d err %0d %s %0d",
                             got.kind, got.value, got.too_big, got.error_code,
                             "base", got.literal_base);
                return;
            end
            want = want_q.pop_front();
            if (got.kind != want.kind || got.value != want.value ||
                got.too_big != want.too_big || got.error_code != want.error_code ||
                got.literal_base != want.literal_base)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                begin
                    $display("mismatch: exp kind %0d value %h too_big %0d err %0d base %0d,",
                             want.kind, want.value, want.too_big, want.error_code,
                             want.literal_base);
                    $display("          got kind %0d value %h too_big %0d err %0d base %0d",
                             got.kind, got.value, got.too_big, got.error_code,
                             got.literal_base);
                end
            end
        endfunction

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        pop       = 1'b0;
    logic [7:0]  character = 8'd0;
    logic        begins    = 1'b0;
    logic        full;
    logic        empty;
    logic [3:0]  kind;
    logic [31:0] value;
    logic        too_big;
    logic [1:0]  error_code;
    logic [1:0]  literal_base;

    literal_scoreboard sb;
    bit quiet      = 1'b0;
    int sent_count = 0;
    int stall_count = 0;

    c_numeric_literal_scanner_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .character    (character),
        .begins       (begins),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .value        (value),
        .too_big      (too_big),
        .error_code   (error_code),
        .literal_base (literal_base)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function bit idle_roll();
        return !quiet && ($urandom_range(0, 99) < 21);
    endfunction

    always @(negedge clk)
    begin
        pop <= rst_n && !idle_roll();
    end

    always @(posedge clk)
    begin
        res_t got;
        bit   moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (push && !full)
            begin
                sb.note_item(character, begins);
                moved = 1'b1;
            end
            if (pop && !empty)
            begin
                got.kind         = kind;
                got.value        = value;
                got.too_big      = too_big;
                got.error_code   = error_code;
                got.literal_base = literal_base;
                sb.check_result(got);
                moved = 1'b1;
            end
            stall_count = moved ? 0 : stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("FAIL c_numeric_literal_scanner_top");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic mark);
        while (idle_roll())
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        character <= c;
        begins    <= mark;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == 0);
    endtask

    function logic [7:0] rcase(logic [7:0] c);
        return $urandom_range(0, 1) ? (c & 8'hDF) : c;
    endfunction

    function logic [7:0] hex_digit();
        int d;
        d = $urandom_range(0, 15);
        return (d < 10) ? 8'("0" + d) : rcase(8'("a" + d - 10));
    endfunction

    function int digit_count();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(6, 14);
    endfunction

    task automatic send_random_literal();
        logic [7:0] q[$];
        int form;
        int n;
        int s;
        logic [7:0] lead;
        form = $urandom_range(0, 9);
        if (form < 6)
        begin
            n = digit_count();
            if (form < 2)
            begin
                q = '{"0", rcase("x")};
                repeat (n) q.push_back(hex_digit());
            end
            else if (form < 4)
            begin
                q = '{"0"};
                repeat (n)
                    q.push_back(($urandom_range(0, 19) == 0) ?
                                "8" : 8'("0" + $urandom_range(0, 7)));
            end
            else
            begin
                q = '{8'("1" + $urandom_range(0, 8))};
                repeat (n) q.push_back(8'("0" + $urandom_range(0, 9)));
            end
            s = $urandom_range(0, 7);
            if (s == 2 || s == 4 || s == 6)
                q.push_back(rcase("u"));
            if (s >= 3)
                q.push_back(rcase("l"));
            if (s == 5 || s == 6)
                q.push_back(rcase("l"));
            if (s == 7)
                q.push_back(rcase("u"));
        end
        else
        begin
            s = ($urandom_range(0, 3) == 0) ? 3 : $urandom_range(0, 2);
            if (s == 3)
                q = '{"."};
            else
            begin
                lead = 8'("0" + $urandom_range(0, 9));
                q    = '{lead};
                repeat ($urandom_range(0, 3))
                    q.push_back((lead == "0") ? 8'("0" + $urandom_range(0, 7)) :
                                                8'("0" + $urandom_range(0, 9)));
                if (s != 1)
                    q.push_back(".");
            end
            if (s != 1)
                repeat ($urandom_range(0, 4)) q.push_back(8'("0" + $urandom_range(0, 9)));
            if (s >= 1 && $urandom_range(0, 2) != 0 || s == 1)
            begin
                q.push_back(rcase("e"));
                if ($urandom_range(0, 1))
                    q.push_back($urandom_range(0, 1) ? "+" : "-");
                repeat ($urandom_range(0, 4)) q.push_back(8'("0" + $urandom_range(0, 9)));
            end
            case ($urandom_range(0, 2))
                1: q.push_back(rcase("f"));
                2: q.push_back(rcase("l"));
                default: ;
            endcase
        end
        foreach (q[i])
            send_byte(q[i], i == 0);
        case ($urandom_range(0, 3))
            1: send_byte(";", 1'b0);
            2: send_byte(" ", 1'b0);
            3: send_byte(8'($urandom_range(0, 255)), 1'b0);
            default: ;
        endcase
    endtask

    initial
    begin
        int target;
        bit drained;
        sb = new();
        drained = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_text("0x;");
        send_text("1e+f;");
        send_text("08");
        send_text("1Ull ");
        send_text("1lu");
        send_text(".;");
        send_text("0XFFFFFFFFF;");
        send_text("z");
        send_text("4294967295u");
        send_text("12");
        send_text("0777L,");
        send_text(".5E9l");
        send_text("7e;");

        target = sent_count + RANDOM_ITEMS;
        while (sent_count < target)
        begin
            quiet = (target - sent_count < 260) && (target - sent_count > 160);
            if (!drained && target - sent_count < 120)
            begin
                push <= 1'b0;
                @(negedge clk);
                while (sb.pending() != 0)
                    @(negedge clk);
                drained = 1'b1;
            end
            if ($urandom_range(0, 99) < 80)
                send_random_literal();
            else
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        quiet = 1'b0;
        send_byte(" ", 1'b0);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS c_numeric_literal_scanner_top");
        else
            $display("FAIL c_numeric_literal_scanner_top");
        $finish;
    end

endmodule
